/* rtl/mclw_pkg.sv */
// Package for the multi-channel link watchdog.
// Default sizes, request mode and result codes, output register type.
// No dependencies.
`default_nettype none

package mclw_pkg;

  localparam int DefChannels   = 16;
  localparam int DefCountWidth = 16;

  localparam int ChanWidth = 4;
  localparam int ThrWidth  = 16;
  localparam int MaskWidth = 16;

  typedef enum logic [1:0] {
    MODE_TICK,
    MODE_FEED,
    MODE_REGISTER,
    MODE_REMOVE
  } mode_e;

  typedef enum logic [2:0] {
    RES_OK,
    RES_NOT_IN_USE,
    RES_DISCONNECTED,
    RES_ONLINE,
    RES_TICK_DONE
  } result_e;

  typedef struct packed {
    result_e              res;
    logic [ChanWidth-1:0] chan;
    logic                 last;
  } out_t;

endpackage

`default_nettype wire

/* rtl/multi_channel_link_watchdog.sv */
// Multi-channel link watchdog: channel table, tick sweep and event sequencer.
// Depends on mclw_pkg.
//
// channel  dir  payload
// s_axis   in   tuser: mode[1:0]; tdata: channel[3:0], threshold_ms[19:4]
// m_axis   out  tuser: event_res[2:0]; tdata: event_channel[3:0],
//                offline_mask[19:4]; tlast: last
// cfg      in   cfg_wdata_i: tick_period_ms
//
// Feed, register and remove: result loaded as the request is taken.
// Tick: one shared saturating add and compare visits one channel per cycle,
// then a scan emits events, one channel per cycle unless the output stalls.
// Reset clears the in-use and fired marks; the count memories need no clearing.
// s_axis_tready is low while a tick is in progress or a result is stalled.
`default_nettype none

module multi_channel_link_watchdog
  import mclw_pkg::*;
#(
  parameter int CHANNELS    = DefChannels,
  parameter int COUNT_WIDTH = DefCountWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // channel, threshold_ms, zero pad
  input  wire logic [1:0]  s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // event_channel, offline_mask, zero pad
  output logic [2:0]       m_axis_tuser,  // event_res
  output logic             m_axis_tlast
);

  localparam int IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW  = $clog2(CHANNELS + 1);
  localparam int TW  = (COUNT_WIDTH > ThrWidth) ? COUNT_WIDTH : ThrWidth;
  localparam int MW  = (CHANNELS > MaskWidth) ? CHANNELS : MaskWidth;
  localparam logic [TW-1:0] CountMax = TW'((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [7:0]             period_q, period_d;
  logic [CHANNELS-1:0]    in_use_q, in_use_d;
  logic [CHANNELS-1:0]    fired_q, fired_d;
  logic [CHANNELS-1:0]    new_fire_q, new_fire_d;
  logic [NW-1:0]          idx_q, idx_d;
  logic                   stage_vld_q, stage_vld_d;
  logic [IW-1:0]          stage_idx_q, stage_idx_d;
  logic                   out_vld_q, out_vld_d;
  out_t                   out_q, out_d;

  logic [COUNT_WIDTH-1:0] elapsed_mem [CHANNELS];
  logic [COUNT_WIDTH-1:0] timeout_mem [CHANNELS];
  logic [COUNT_WIDTH-1:0] elapsed_rd_q, timeout_rd_q;
  logic [IW-1:0]          rd_addr;

  logic                   el_we, to_we;
  logic [IW-1:0]          el_addr, to_addr;
  logic [COUNT_WIDTH-1:0] el_wdata, to_wdata;

  mode_e                  mode;
  logic [ChanWidth-1:0]   chan_in;
  logic [ThrWidth-1:0]    thr_in;
  logic [IW-1:0]          ch_idx;
  logic                   ch_ok;
  logic [TW-1:0]          thr_ext;
  logic [COUNT_WIDTH-1:0] thr_sat;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sum_sat;
  logic                   in_acc, out_free;
  logic [MW-1:0]          fired_ext;

  assign mode    = mode_e'(s_axis_tuser);
  assign chan_in = s_axis_tdata[ChanWidth-1:0];
  assign thr_in  = s_axis_tdata[ChanWidth+ThrWidth-1:ChanWidth];
  assign ch_idx  = IW'(chan_in);
  assign ch_ok   = 32'(chan_in) < CHANNELS;
  assign thr_ext = TW'(thr_in);
  assign thr_sat = (thr_ext > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                        : thr_ext[COUNT_WIDTH-1:0];
  assign sum     = {1'b0, elapsed_rd_q} + (COUNT_WIDTH+1)'(period_q);
  assign sum_sat = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rd_addr       = idx_q[IW-1:0];

  assign fired_ext     = MW'(fired_q);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.res;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {4'b0, fired_ext[MaskWidth-1:0], out_q.chan};

  always_comb begin
    state_d     = state_q;
    period_d    = cfg_we_i ? cfg_wdata_i : period_q;
    in_use_d    = in_use_q;
    fired_d     = fired_q;
    new_fire_d  = new_fire_q;
    idx_d       = idx_q;
    stage_vld_d = 1'b0;
    stage_idx_d = stage_idx_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_d       = out_q;
    el_we       = 1'b0;
    el_addr     = ch_idx;
    el_wdata    = '0;
    to_we       = 1'b0;
    to_addr     = ch_idx;
    to_wdata    = thr_sat;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_d.chan = chan_in;
          out_d.last = 1'b1;
          out_d.res  = RES_NOT_IN_USE;
          if (mode == MODE_TICK) begin
            state_d    = ST_SWEEP;
            idx_d      = '0;
            new_fire_d = '0;
          end else begin
            out_vld_d = 1'b1;
            if (ch_ok) begin
              case (mode)
                MODE_FEED: begin
                  if (in_use_q[ch_idx]) begin
                    fired_d[ch_idx] = 1'b0;
                    el_we           = 1'b1;
                    out_d.res       = RES_ONLINE;
                  end
                end
                MODE_REGISTER: begin
                  in_use_d[ch_idx] = 1'b1;
                  fired_d[ch_idx]  = 1'b0;
                  el_we            = 1'b1;
                  to_we            = 1'b1;
                  out_d.res        = RES_OK;
                end
                MODE_REMOVE: begin
                  if (in_use_q[ch_idx]) begin
                    in_use_d[ch_idx] = 1'b0;
                    fired_d[ch_idx]  = 1'b0;
                    out_d.res        = RES_OK;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      ST_SWEEP: begin
        if (32'(idx_q) < CHANNELS) begin
          stage_vld_d = 1'b1;
          stage_idx_d = idx_q[IW-1:0];
          idx_d       = idx_q + 1'b1;
        end else if (!stage_vld_q) begin
          state_d = ST_EMIT;
          idx_d   = '0;
        end
        if (stage_vld_q && in_use_q[stage_idx_q]) begin
          el_we    = 1'b1;
          el_addr  = stage_idx_q;
          el_wdata = sum_sat;
          if (sum_sat >= timeout_rd_q && !fired_q[stage_idx_q]) begin
            fired_d[stage_idx_q]    = 1'b1;
            new_fire_d[stage_idx_q] = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (32'(idx_q) >= CHANNELS) begin
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_d.res  = RES_TICK_DONE;
            out_d.chan = '0;
            out_d.last = 1'b1;
            new_fire_d = '0;
            state_d    = ST_IDLE;
          end
        end else if (new_fire_q[idx_q[IW-1:0]]) begin
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_d.res  = RES_DISCONNECTED;
            out_d.chan = ChanWidth'(idx_q);
            out_d.last = 1'b0;
            idx_d      = idx_q + 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= 8'd1;
      in_use_q    <= '0;
      fired_q     <= '0;
      new_fire_q  <= '0;
      idx_q       <= '0;
      stage_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      period_q    <= period_d;
      in_use_q    <= in_use_d;
      fired_q     <= fired_d;
      new_fire_q  <= new_fire_d;
      idx_q       <= idx_d;
      stage_vld_q <= stage_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_idx_q <= stage_idx_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (el_we) begin
      elapsed_mem[el_addr] <= el_wdata;
    end
    elapsed_rd_q <= elapsed_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (to_we) begin
      timeout_mem[to_addr] <= to_wdata;
    end
    timeout_rd_q <= timeout_mem[rd_addr];
  end

  // checks
  a_new_fire_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (new_fire_q & ~fired_q) == '0)
    else $error("new-fire mark without fired mark");

  a_fired_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fired_q & ~in_use_q) == '0)
    else $error("fired mark on unused channel");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!out_vld_q || m_axis_tready))
    else $error("request taken while result stalled");

  a_tick_done_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.res == RES_TICK_DONE) |-> (m_axis_tlast && out_q.chan == '0))
    else $error("malformed tick-done result");

  a_disc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.res == RES_DISCONNECTED) |-> (!m_axis_tlast && state_q == ST_EMIT))
    else $error("disconnect result outside event scan");

endmodule

`default_nettype wire
